@@ hdl/rfp_pkg.sv @@
// Package: parser state, result record and shared codes for the request frame parser.
package rfp_pkg;

    // Parser phases; also the byte_kind codes of a result
    localparam logic [2:0] PH_FLEN = 3'd0;
    localparam logic [2:0] PH_ACNT = 3'd1;
    localparam logic [2:0] PH_SLEN = 3'd2;
    localparam logic [2:0] PH_PAY  = 3'd3;
    localparam logic [2:0] PH_DROP = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_LONG = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    // Register reset values
    localparam logic [31:0] MAX_MESSAGE_LEN_RST = 32'd33554432;
    localparam logic [31:0] MAX_ARGS_RST        = 32'd200000;

    // Register indexes (byte address bit 2)
    localparam logic REG_MAX_MESSAGE_LEN = 1'b0;
    localparam logic REG_MAX_ARGS        = 1'b1;

    // Smallest body: room for one 4-byte field
    localparam logic [31:0] FIELD_BYTES = 32'd4;

    typedef struct packed {
        logic [2:0]  phase;
        logic [1:0]  field_byte_pos;
        logic [23:0] field_shift;
        logic [31:0] frame_left;
        logic [31:0] args_left;
        logic [31:0] string_left;
        logic [31:0] current_arg;
        logic [1:0]  error_code;
    } rfp_state_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [2:0]  byte_kind;
        logic [31:0] arg_index;
        logic        string_done;
        logic        request_done;
        logic [1:0]  status;
    } rfp_result_t;

endpackage

@@ hdl/rfp_ifs.sv @@
// Interfaces: input byte channel and tagged result channel.
interface rfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       conn_start;

    modport source (output valid, output in_byte, output conn_start, input ready);
    modport sink   (input valid, input in_byte, input conn_start, output ready);
endinterface

interface rfp_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic [2:0]  byte_kind;
    logic [31:0] arg_index;
    logic        string_done;
    logic        request_done;
    logic [1:0]  status;

    modport source (output valid, output out_byte, output byte_kind, output arg_index,
                    output string_done, output request_done, output status, input ready);
    modport sink   (input valid, input out_byte, input byte_kind, input arg_index,
                    input string_done, input request_done, input status, output ready);
endinterface

@@ hdl/rfp_core.sv @@
// Per-byte next-state and result logic of the request frame parser.
module rfp_core
(
    input  rfp_pkg::rfp_state_t  cur_state,
    input  logic [7:0]           in_byte,
    input  logic                 conn_start,
    input  logic [31:0]          max_message_len,
    input  logic [31:0]          max_args,
    output rfp_pkg::rfp_state_t  next_state,
    output rfp_pkg::rfp_result_t result
);

    rfp_pkg::rfp_state_t st;
    logic        complete;
    logic [31:0] field;
    logic [31:0] frame_dec;
    logic [31:0] args_dec;
    logic [31:0] string_dec;
    logic [31:0] arg_inc;
    logic [1:0]  pos_inc;
    logic [23:0] shift_acc;

    // conn_start clears the parser before the byte is used (reset state is all zero)
    assign st = conn_start ? '0 : cur_state;

    // Shared datapath terms
    assign complete   = (st.field_byte_pos == 2'd3);
    assign field      = {in_byte, st.field_shift};
    assign frame_dec  = st.frame_left - 32'd1;
    assign args_dec   = st.args_left - 32'd1;
    assign string_dec = st.string_left - 32'd1;
    assign arg_inc    = st.current_arg + 32'd1;
    assign pos_inc    = st.field_byte_pos + 2'd1;
    assign shift_acc  = st.field_shift | (24'(in_byte) << {st.field_byte_pos, 3'b000});

    always_comb
    begin
        next_state          = st;
        result.out_byte     = in_byte;
        result.byte_kind    = rfp_pkg::PH_DROP;
        result.arg_index    = '0;
        result.string_done  = 1'b0;
        result.request_done = 1'b0;

        // Field gather for the three field phases
        if ((st.error_code == rfp_pkg::ST_OK) && (st.phase != rfp_pkg::PH_PAY)
            && (st.phase != rfp_pkg::PH_DROP))
        begin
            if (complete)
            begin
                next_state.field_byte_pos = 2'd0;
                next_state.field_shift    = '0;
            end
            else
            begin
                next_state.field_byte_pos = pos_inc;
                next_state.field_shift    = shift_acc;
            end
        end

        if (st.error_code != rfp_pkg::ST_OK)
        begin
            result.byte_kind = rfp_pkg::PH_DROP;
        end
        else
        begin
            case (st.phase)
                rfp_pkg::PH_FLEN:
                begin
                    result.byte_kind = rfp_pkg::PH_FLEN;
                    if (complete)
                    begin
                        if (field > max_message_len)
                        begin
                            next_state.error_code = rfp_pkg::ST_LONG;
                            next_state.phase      = rfp_pkg::PH_DROP;
                        end
                        else if (field < rfp_pkg::FIELD_BYTES)
                        begin
                            next_state.error_code = rfp_pkg::ST_BAD;
                            next_state.phase      = rfp_pkg::PH_DROP;
                        end
                        else
                        begin
                            next_state.frame_left = field;
                            next_state.phase      = rfp_pkg::PH_ACNT;
                        end
                    end
                end
                rfp_pkg::PH_ACNT:
                begin
                    result.byte_kind      = rfp_pkg::PH_ACNT;
                    next_state.frame_left = frame_dec;
                    if (complete)
                    begin
                        next_state.current_arg = '0;
                        if (field > max_args)
                        begin
                            next_state.error_code = rfp_pkg::ST_BAD;
                            next_state.phase      = rfp_pkg::PH_DROP;
                        end
                        else if (field == 32'd0)
                        begin
                            if (frame_dec == 32'd0)
                            begin
                                result.request_done = 1'b1;
                                next_state.phase    = rfp_pkg::PH_FLEN;
                            end
                            else
                            begin
                                next_state.error_code = rfp_pkg::ST_BAD;
                                next_state.phase      = rfp_pkg::PH_DROP;
                            end
                        end
                        else if (frame_dec < rfp_pkg::FIELD_BYTES)
                        begin
                            next_state.error_code = rfp_pkg::ST_BAD;
                            next_state.phase      = rfp_pkg::PH_DROP;
                        end
                        else
                        begin
                            next_state.args_left = field;
                            next_state.phase     = rfp_pkg::PH_SLEN;
                        end
                    end
                end
                rfp_pkg::PH_SLEN, rfp_pkg::PH_PAY:
                begin
                    result.byte_kind      = st.phase;
                    result.arg_index      = st.current_arg;
                    next_state.frame_left = frame_dec;
                    if ((st.phase == rfp_pkg::PH_SLEN) && complete
                        && (field > frame_dec))
                    begin
                        // String would run past the frame end
                        next_state.error_code = rfp_pkg::ST_BAD;
                        next_state.phase      = rfp_pkg::PH_DROP;
                    end
                    else if ((st.phase == rfp_pkg::PH_SLEN) && complete
                             && (field != 32'd0))
                    begin
                        next_state.string_left = field;
                        next_state.phase       = rfp_pkg::PH_PAY;
                    end
                    else if (((st.phase == rfp_pkg::PH_SLEN) && complete)
                             || ((st.phase == rfp_pkg::PH_PAY) && (string_dec == 32'd0)))
                    begin
                        // Argument string finished: next one or end of frame
                        result.string_done     = 1'b1;
                        next_state.current_arg = arg_inc;
                        next_state.args_left   = args_dec;
                        if (args_dec == 32'd0)
                        begin
                            if (frame_dec == 32'd0)
                            begin
                                result.request_done = 1'b1;
                                next_state.phase    = rfp_pkg::PH_FLEN;
                            end
                            else
                            begin
                                // Trailing bytes after the last argument
                                next_state.error_code = rfp_pkg::ST_BAD;
                                next_state.phase      = rfp_pkg::PH_DROP;
                            end
                        end
                        else if (frame_dec < rfp_pkg::FIELD_BYTES)
                        begin
                            next_state.error_code = rfp_pkg::ST_BAD;
                            next_state.phase      = rfp_pkg::PH_DROP;
                        end
                        else
                        begin
                            next_state.phase = rfp_pkg::PH_SLEN;
                        end
                    end
                    if (st.phase == rfp_pkg::PH_PAY)
                    begin
                        next_state.string_left = string_dec;
                    end
                end
                default:
                begin
                    result.byte_kind = rfp_pkg::PH_DROP;
                end
            endcase
        end

        // Error byte or dropped byte: no completion flags
        if (next_state.error_code != rfp_pkg::ST_OK)
        begin
            result.string_done  = 1'b0;
            result.request_done = 1'b0;
            if (result.byte_kind == rfp_pkg::PH_DROP)
            begin
                result.arg_index = '0;
            end
        end
        result.status = next_state.error_code;
    end

endmodule

@@ hdl/request_frame_parser.sv @@
// Top level: length-prefixed request frame parser with APB limit registers.
//
//  channel   dir  transfer                  payload
//  in_ch     in   valid & ready             in_byte, conn_start
//  out_ch    out  valid & ready             out_byte, byte_kind, arg_index,
//                                           string_done, request_done, status
//  apb       in   psel&penable&pwrite       paddr[2] selects register, pwdata
//
//  One byte per cycle if not stalled; each result shows the cycle after its byte
//  transfers, set by the single result register after the per-byte counter/compare logic.
//  A new byte is taken while the result register is empty or being emptied.
//  A stall on out_ch holds the result and deasserts in_ch.ready.
//  rst_n clears the parser state and loads the limit registers with defaults.
module request_frame_parser
(
    input  logic               clk,
    input  logic               rst_n,
    rfp_in_if.sink             in_ch,
    rfp_out_if.source          out_ch,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    rfp_pkg::rfp_state_t  state_reg;
    rfp_pkg::rfp_state_t  state_next;
    rfp_pkg::rfp_result_t result_next;
    rfp_pkg::rfp_result_t result_reg;
    logic                 out_valid_reg;
    logic [31:0]          max_message_len_reg;
    logic [31:0]          max_args_reg;
    logic                 in_xfer;
    logic                 cfg_write;

    // Register port
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;
    assign prdata    = (paddr[2] == rfp_pkg::REG_MAX_ARGS) ? max_args_reg
                                                           : max_message_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_message_len_reg <= rfp_pkg::MAX_MESSAGE_LEN_RST;
            max_args_reg        <= rfp_pkg::MAX_ARGS_RST;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == rfp_pkg::REG_MAX_ARGS)
            begin
                max_args_reg <= pwdata;
            end
            else
            begin
                max_message_len_reg <= pwdata;
            end
        end
    end

    // Per-byte logic
    rfp_core u_core
    (
        .cur_state       (state_reg),
        .in_byte         (in_ch.in_byte),
        .conn_start      (in_ch.conn_start),
        .max_message_len (max_message_len_reg),
        .max_args        (max_args_reg),
        .next_state      (state_next),
        .result          (result_next)
    );

    // Handshake: accept while result register is free or draining
    assign in_ch.ready = ~out_valid_reg | out_ch.ready;
    assign in_xfer     = in_ch.valid & in_ch.ready;

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (in_xfer)
        begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            result_reg <= result_next;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.out_byte     = result_reg.out_byte;
    assign out_ch.byte_kind    = result_reg.byte_kind;
    assign out_ch.arg_index    = result_reg.arg_index;
    assign out_ch.string_done  = result_reg.string_done;
    assign out_ch.request_done = result_reg.request_done;
    assign out_ch.status       = result_reg.status;

endmodule

@@ hdl/rfp_checker.sv @@
// Port-level checker for the request frame parser, bound to the top level.
module rfp_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  byte_kind,
    input logic [31:0] arg_index,
    input logic        string_done,
    input logic        request_done,
    input logic [1:0]  status
);

    // A stalled result stays valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // Every input transfer produces a result in the next cycle
    a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("no result after input transfer");

    // Dropped bytes carry an error and no tags
    a_drop_tags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (byte_kind == rfp_pkg::PH_DROP) |->
        (status != rfp_pkg::ST_OK) && (arg_index == 32'd0) && !string_done && !request_done)
        else $error("dropped byte with bad tags");

    // Completion flags only on clean body bytes
    a_done_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (string_done || request_done) |->
        (status == rfp_pkg::ST_OK) && ((byte_kind == rfp_pkg::PH_ACNT)
        || (byte_kind == rfp_pkg::PH_SLEN) || (byte_kind == rfp_pkg::PH_PAY)))
        else $error("completion flag on wrong byte");

endmodule

bind request_frame_parser rfp_checker u_rfp_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .byte_kind    (out_ch.byte_kind),
    .arg_index    (out_ch.arg_index),
    .string_done  (out_ch.string_done),
    .request_done (out_ch.request_done),
    .status       (out_ch.status)
);
